// ===== rtl/core/ssym_pkg.sv =====
// Shared types and constants for the scoped symbol table.
`default_nettype none

package ssym_pkg;

    typedef enum logic [1:0] {
        ACT_ENTER  = 2'd0,
        ACT_LEAVE  = 2'd1,
        ACT_BIND   = 2'd2,
        ACT_LOOKUP = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SCOPE_FULL = 3'd1,
        ST_OUTERMOST  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_DUPLICATE  = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } status_t;

    typedef struct packed {
        logic [5:0] slot;
        logic       mut;
        logic [3:0] depth;
        status_t    status;
    } res_t;

    localparam int M_DATA_W = 16;

endpackage

`default_nettype wire

// ===== rtl/core/ssym_entry_mem.sv =====
// Entry store: one write port, one registered read port.
`default_nettype none

module ssym_entry_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 21,
    parameter int AW    = 6
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ssym_seq.sv =====
// Sequencer: scope stack, entry count and the shared key comparator scan.
`default_nettype none

module ssym_seq #(
    parameter int MAX_SCOPES  = 16,
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16,
    parameter int DEP_W       = 4,
    parameter int CNT_W       = 7,
    parameter int IDX_W       = 6,
    parameter int ENT_W       = 21
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ssym_pkg::action_t     in_action,
    input  wire logic [KEY_BITS-1:0]   in_key,
    input  wire logic                  in_mut,
    input  wire logic                  out_free,
    output logic                       res_valid,
    output ssym_pkg::res_t             res,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output logic [ENT_W-1:0]           wr_data,
    output logic [IDX_W-1:0]           rd_addr,
    input  wire logic [ENT_W-1:0]      rd_data
);

    import ssym_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    action_t              act_reg, act_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic                 mut_reg, mut_next;
    logic [DEP_W-1:0]     depth_reg, depth_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scope_start_reg [MAX_SCOPES];
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     lo_reg, lo_next;
    res_t                 res_reg, res_next;

    logic                 ss_we;
    logic [DEP_W-1:0]     ss_idx;
    logic [CNT_W-1:0]     cur_start;
    logic [CNT_W-1:0]     count_m1;
    logic                 hit;
    logic [DEP_W+3:0]     hit_depth_ext;
    logic [IDX_W+5:0]     hit_slot_ext;

    assign cur_start     = scope_start_reg[depth_reg];
    assign ss_idx        = depth_reg + 1'b1;
    assign count_m1      = count_reg - 1'b1;
    assign hit           = rd_data[KEY_BITS-1:0] == key_reg;
    assign hit_depth_ext = {4'b0, rd_data[KEY_BITS+1 +: DEP_W]};
    assign hit_slot_ext  = {6'b0, idx_reg};
    assign wr_addr       = count_reg[IDX_W-1:0];
    assign wr_data       = {depth_reg, mut_reg, key_reg};
    assign res           = res_reg;

    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        mut_next   = mut_reg;
        depth_next = depth_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        res_next   = res_reg;
        ss_we      = 1'b0;
        wr_en      = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_addr    = idx_reg - 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    act_next   = in_action;
                    key_next   = in_key;
                    mut_next   = in_mut;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_next        = '0;
                res_next.status = ST_OK;
                state_next      = S_FIN;
                unique case (act_reg)
                    ACT_ENTER: begin
                        if (depth_reg == DEP_W'(MAX_SCOPES - 1)) begin
                            res_next.status = ST_SCOPE_FULL;
                        end else begin
                            depth_next = ss_idx;
                            ss_we      = 1'b1;
                        end
                    end
                    ACT_LEAVE: begin
                        if (depth_reg == '0) begin
                            res_next.status = ST_OUTERMOST;
                        end else begin
                            count_next = cur_start;
                            depth_next = depth_reg - 1'b1;
                        end
                    end
                    ACT_BIND: begin
                        if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                            res_next.status = ST_TABLE_FULL;
                        end else if (count_reg == cur_start) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end else begin
                            idx_next   = count_m1[IDX_W-1:0];
                            lo_next    = cur_start[IDX_W-1:0];
                            rd_addr    = count_m1[IDX_W-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    ACT_LOOKUP: begin
                        if (count_reg == '0) begin
                            res_next.status = ST_NOT_FOUND;
                        end else begin
                            idx_next   = count_m1[IDX_W-1:0];
                            lo_next    = '0;
                            rd_addr    = count_m1[IDX_W-1:0];
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                // rd_data holds entry idx_reg; walk from newest toward lo_reg
                if (hit) begin
                    state_next = S_FIN;
                    if (act_reg == ACT_BIND) begin
                        res_next.status = ST_DUPLICATE;
                    end else begin
                        res_next.status = ST_OK;
                        res_next.depth  = hit_depth_ext[3:0];
                        res_next.mut    = rd_data[KEY_BITS];
                        res_next.slot   = hit_slot_ext[5:0];
                    end
                end else if (idx_reg == lo_reg) begin
                    state_next = S_FIN;
                    if (act_reg == ACT_BIND) begin
                        wr_en           = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_next.status = ST_OK;
                    end else begin
                        res_next.status = ST_NOT_FOUND;
                    end
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            depth_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_SCOPES; i++) begin
                scope_start_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            count_reg <= count_next;
            if (ss_we) begin
                scope_start_reg[ss_idx] <= count_reg;
            end
        end
        act_reg <= act_next;
        key_reg <= key_next;
        mut_reg <= mut_next;
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/scoped_symbol_table.sv =====
// Top level of the scoped symbol table with its stream ports and output register.
`default_nettype none

// Nested-scope symbol table. Each input item carries an action in s_tuser
// (enter, leave, bind, lookup) and a key with a mutability flag in s_tdata;
// each item gives exactly one result item with a status and, for a lookup
// hit, the depth, mutability and slot of the newest matching entry. The block
// takes one item at a time: enter and leave go from acceptance through a decide
// state to the result; bind and lookup also scan up to MAX_ENTRIES entries
// in between, because a single key comparator
// reads the entry memory one entry per cycle from the newest entry down.
// A registered output holds the result until it is taken. The entry memory
// needs no clearing after reset; only entries below the fill count are read.
module scoped_symbol_table #(
    parameter int MAX_SCOPES  = 16,
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // key[KEY_BITS-1:0], mutable_flag[KEY_BITS], zero fill
    input  wire logic [((KEY_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]                             s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // status[2:0], found_depth[6:3], found_mutable[7], found_slot[13:8], zero fill
    output logic [ssym_pkg::M_DATA_W-1:0]               m_tdata
);

    import ssym_pkg::*;

    localparam int DEP_W = $clog2(MAX_SCOPES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_W = KEY_BITS + 1 + DEP_W;

    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg;
    logic              out_free;
    logic              res_valid;
    res_t              res;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [ENT_W-1:0]  rd_data;

    assign out_free = !m_valid_reg || m_tready;

    ssym_seq #(
        .MAX_SCOPES  (MAX_SCOPES),
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .DEP_W       (DEP_W),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W),
        .ENT_W       (ENT_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (action_t'(s_tuser)),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_mut    (s_tdata[KEY_BITS]),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ssym_entry_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b0, m_res_reg};

`ifndef ASSERT_OFF
    a_one_item_at_a_time: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("new item accepted while one is in progress");

    a_no_result_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_tvalid || m_tready)
    ) else $error("result written over an untaken result");

    a_miss_fields_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:0] != ST_OK)) |-> (m_tdata[13:3] == '0)
    ) else $error("found fields nonzero on a failing status");
`endif

endmodule

`default_nettype wire

// ===== sim/ssym_checker.sv =====
// Result predictor and stream checker for the scoped symbol table testbench.
module ssym_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // key[15:0], mutable_flag[16], zero fill
    input  wire logic [23:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // status[2:0], found_depth[6:3], found_mutable[7], found_slot[13:8], zero fill
    input  wire logic [15:0] m_tdata,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssym_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int SCOPE_LIMIT = 16;

    logic [15:0] sym_key   [TABLE_DEPTH];
    logic        sym_mut   [TABLE_DEPTH];
    logic [3:0]  sym_depth [TABLE_DEPTH];
    int          fill;
    int          scope_lvl;
    int          scope_base [SCOPE_LIMIT];

    res_t        pending_q [$];
    res_t        got;
    res_t        want;

    // Applies one action to the shadow table and returns the result it gives.
    function automatic res_t resolve_action(action_t act, logic [15:0] key, logic mflag);
        res_t r;
        int   idx;
        bit   dup;
        r = '0;
        r.status = ST_OK;
        dup = 1'b0;
        case (act)
            ACT_ENTER: begin
                if (scope_lvl + 1 >= SCOPE_LIMIT) begin
                    r.status = ST_SCOPE_FULL;
                end else begin
                    scope_lvl++;
                    scope_base[scope_lvl] = fill;
                end
            end
            ACT_LEAVE: begin
                if (scope_lvl == 0) begin
                    r.status = ST_OUTERMOST;
                end else begin
                    fill = scope_base[scope_lvl];
                    scope_lvl--;
                end
            end
            ACT_BIND: begin
                if (fill >= TABLE_DEPTH) begin
                    r.status = ST_TABLE_FULL;
                end else begin
                    for (idx = scope_base[scope_lvl]; idx < fill; idx++) begin
                        if (sym_key[idx] == key) dup = 1'b1;
                    end
                    if (dup) begin
                        r.status = ST_DUPLICATE;
                    end else begin
                        sym_key[fill]   = key;
                        sym_mut[fill]   = mflag;
                        sym_depth[fill] = 4'(scope_lvl);
                        fill++;
                    end
                end
            end
            default: begin
                r.status = ST_NOT_FOUND;
                for (idx = fill - 1; idx >= 0; idx--) begin
                    if (r.status == ST_NOT_FOUND && sym_key[idx] == key) begin
                        r.status = ST_OK;
                        r.depth  = sym_depth[idx];
                        r.mut    = sym_mut[idx];
                        r.slot   = 6'(idx);
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill       = 0;
            scope_lvl  = 0;
            mismatches = 0;
            foreach (scope_base[i]) scope_base[i] = 0;
            pending_q.delete();
            outstanding <= 0;
        end else begin
            // retire the older item before taking in a new one on the same edge
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[13:0]);
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %h with no item pending", $realtime, m_tdata);
                end else begin
                    want = pending_q.pop_front();
                    if (got.status !== want.status || got.depth !== want.depth ||
                        got.mut !== want.mut || got.slot !== want.slot ||
                        m_tdata[15:14] !== 2'b00) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: status/depth/mut/slot expected %0d/%0d/%0d/%0d",
                                      " got %0d/%0d/%0d/%0d (fill %b)"},
                                     $realtime, want.status, want.depth, want.mut,
                                     want.slot, got.status, got.depth, got.mut, got.slot,
                                     m_tdata[15:14]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_q.push_back(resolve_action(action_t'(s_tuser), s_tdata[15:0],
                                                   s_tdata[16]));
            outstanding <= pending_q.size();
        end
    end

endmodule

// ===== sim/tb_scoped_symbol_table.sv =====
// Stimulus, clocking and verdict for the scoped symbol table testbench.
module tb_scoped_symbol_table;
    timeunit 1ns;
    timeprecision 1ps;
    import ssym_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_ENTER;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          mismatches;
    int          outstanding;

    bit          tx_idle = 1'b0;
    bit          rx_idle = 1'b0;
    int          stall_left = 0;
    int          items_sent = 0;
    int          stim_depth = 0;
    logic [15:0] key_pool [8];

    scoped_symbol_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ssym_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side back-pressure in bursts, only while rx_idle is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(input action_t act, input logic [15:0] key, input logic mflag);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, mflag, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        // depth is tracked only to steer the stimulus
        if (act == ACT_ENTER && stim_depth < 15) stim_depth++;
        if (act == ACT_LEAVE && stim_depth > 0) stim_depth--;
    endtask

    task automatic send_scope(input action_t act);
        send(act, 16'($urandom), 1'($urandom));
    endtask

    task automatic refresh_pool();
        foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    endtask

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic unwind();
        while (stim_depth > 0) send_scope(ACT_LEAVE);
        if ($urandom_range(0, 2) == 0) send_scope(ACT_LEAVE);
    endtask

    // distinct keys until the table overflows, then a bind that is both full and a repeat
    task automatic fill_table();
        logic [15:0] base;
        int          n;
        base = 16'($urandom);
        unwind();
        repeat ($urandom_range(1, 3)) send_scope(ACT_ENTER);
        for (n = 0; n < 66; n++) begin
            if ($urandom_range(0, 15) == 0) send_scope(ACT_ENTER);
            send(ACT_BIND, base + 16'(n), 1'($urandom));
            if ($urandom_range(0, 5) == 0)
                send(ACT_LOOKUP, base + 16'($urandom_range(0, n)), 1'($urandom));
        end
        send(ACT_BIND, base, 1'($urandom));
        send(ACT_LOOKUP, base + 16'd61, 1'($urandom));
        send(ACT_LOOKUP, base, 1'($urandom));
        send(ACT_LOOKUP, 16'($urandom), 1'($urandom));
        unwind();
    endtask

    // nest to the scope limit and two enters past it, with shadowing binds on the way
    task automatic dive();
        int lvl;
        refresh_pool();
        unwind();
        for (lvl = 0; lvl < 17; lvl++) begin
            send_scope(ACT_ENTER);
            repeat ($urandom_range(0, 2)) send(ACT_BIND, pick_key(), 1'($urandom));
            send(ACT_LOOKUP, pick_key(), 1'($urandom));
        end
        while (stim_depth > 0) begin
            send_scope(ACT_LEAVE);
            send(ACT_LOOKUP, pick_key(), 1'($urandom));
        end
    endtask

    task automatic churn(input int count);
        int pick;
        refresh_pool();
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_scope(ACT_ENTER);
            end else if (pick < 42) begin
                send_scope(ACT_LEAVE);
            end else if (pick < 72) begin
                // outermost scope stays nearly empty so the table keeps room
                if (stim_depth == 0) send_scope(ACT_ENTER);
                else send(ACT_BIND, pick_key(), 1'($urandom));
            end else begin
                send(ACT_LOOKUP, pick_key(), 1'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(ACT_LOOKUP, 16'h1234, 1'b0);
        send(ACT_LEAVE,  16'hFFFF, 1'b1);
        send(ACT_BIND,   16'h0000, 1'b0);
        send(ACT_BIND,   16'hFFFF, 1'b1);
        send(ACT_BIND,   16'h0000, 1'b1);
        send(ACT_LOOKUP, 16'hFFFF, 1'b0);
        send(ACT_LOOKUP, 16'h0000, 1'b1);
        send(ACT_ENTER,  16'hFFFF, 1'b1);
        send(ACT_BIND,   16'h0000, 1'b1);
        send(ACT_LOOKUP, 16'h0000, 1'b0);
        send(ACT_BIND,   16'hFFFF, 1'b0);
        send(ACT_LOOKUP, 16'hFFFF, 1'b1);
        send(ACT_LEAVE,  16'h0000, 1'b0);
        send(ACT_LOOKUP, 16'h0000, 1'b0);
        send(ACT_LOOKUP, 16'hABCD, 1'b1);
        send(ACT_LEAVE,  16'h5555, 1'b0);

        tx_idle <= 1'b1;
        rx_idle <= 1'b1;
        dive();
        fill_table();
        while (items_sent < 1200) begin
            tx_idle <= ($urandom_range(0, 3) != 0);
            rx_idle <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       dive();
                1:       fill_table();
                default: churn($urandom_range(20, 60));
            endcase
        end
        tx_idle <= 1'b0;
        rx_idle <= 1'b0;
        churn(150);
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[scoped_symbol_table] OK");
        end else begin
            $display("[scoped_symbol_table] ERROR");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("[scoped_symbol_table] ERROR");
        $finish;
    end

endmodule
